>>> hw/rtl/complex_mul_div_unit_core_macros.svh
// Assertion macros for the complex multiply/divide unit.
// Expects clk and rst_n in the scope of each use.
`ifndef COMPLEX_MUL_DIV_UNIT_CORE_MACROS_SVH
`define COMPLEX_MUL_DIV_UNIT_CORE_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define CMDU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising clk edge outside reset.
`define CMDU_ASSERT_IMP(label, cond, prop, msg) \
    `CMDU_ASSERT(label, (cond) |-> (prop), msg)

`endif

>>> hw/rtl/cmdu_pkg.sv
// Shared types, constants and helpers of the complex multiply/divide unit.
// No dependencies.
package cmdu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 32 - FRAC_BITS;
    // quotient bits: integer part, fraction, one rounding bit
    localparam int QBITS     = INT_BITS + FRAC_BITS + 1;
    localparam int DIV_STEPS = QBITS;
    // product, sum, setup, divide steps, output
    localparam int LATENCY   = DIV_STEPS + 4;

    typedef enum logic
    {
        CMD_MUL = 1'b0,
        CMD_DIV = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } req_t;

    typedef struct packed
    {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               overflow;
        logic               div_zero;
    } rsp_t;

    typedef struct packed
    {
        logic [63:0]      rem;
        logic [QBITS-1:0] num;
        logic [QBITS-1:0] quo;
        logic             big;
        logic             neg;
    } lane_t;

    typedef struct packed
    {
        cmd_t        cmd;
        logic        dz;
        logic [31:0] mul_re;
        logic [31:0] mul_im;
        logic        mul_ovf;
        logic [63:0] den;
        lane_t       re;
        lane_t       im;
    } div_t;

    // {overflow, value}: saturate a sign and magnitude to 32-bit two's complement
    function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
        logic [63:0] neg_mag;
        neg_mag = 64'd0 - mag;
        if (!neg)
        begin
            if (mag > 64'h7FFF_FFFF)
                sat32 = {1'b1, 32'h7FFF_FFFF};
            else
                sat32 = {1'b0, mag[31:0]};
        end
        else
        begin
            if (mag > 64'h8000_0000)
                sat32 = {1'b1, 32'h8000_0000};
            else
                sat32 = {1'b0, neg_mag[31:0]};
        end
    endfunction

endpackage

>>> hw/rtl/complex_mul_div_unit_core.sv
// Channel   Handshake        Payload
// request   start / busy     req   (cmdu_pkg::req_t)
// result    done strobe      rsp   (cmdu_pkg::rsp_t)
//
// A request is taken every cycle; busy stays low.
// Each result passes three front stages,
// one stage per quotient bit of the 33-bit restoring divider and one output stage.
// Multiply requests ride the same pipeline, so results keep request order.
// Reset clears the valid bits only. The receiver cannot stall, so nothing holds.
// Depends on cmdu_pkg, cmdu_front, cmdu_div_stage, cmdu_back and the macro header.
`include "complex_mul_div_unit_core_macros.svh"

module complex_mul_div_unit_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  cmdu_pkg::req_t req,
    output logic           done,
    output cmdu_pkg::rsp_t rsp
);

    logic           valid_chain [cmdu_pkg::DIV_STEPS+1];
    cmdu_pkg::div_t data_chain  [cmdu_pkg::DIV_STEPS+1];

    assign busy = 1'b0;

    cmdu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .req       (req),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0])
    );

    for (genvar i = 0; i < cmdu_pkg::DIV_STEPS; i++)
    begin : g_div
        cmdu_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[i]),
            .in_data   (data_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_data  (data_chain[i+1])
        );
    end

    cmdu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_chain[cmdu_pkg::DIV_STEPS]),
        .in_data  (data_chain[cmdu_pkg::DIV_STEPS]),
        .done     (done),
        .rsp      (rsp)
    );

    `CMDU_ASSERT_IMP(a_latency, start, ##(cmdu_pkg::LATENCY) done, "result strobe missing")
    `CMDU_ASSERT_IMP(a_no_extra, done, $past(start, cmdu_pkg::LATENCY), "result without request")
    `CMDU_ASSERT_IMP(a_dz_zero, done && rsp.div_zero,
        rsp.res_re == 32'sd0 && rsp.res_im == 32'sd0 && !rsp.overflow, "div by zero not zero")
    `CMDU_ASSERT(a_never_busy, !busy, "busy raised")

endmodule

>>> hw/rtl/cmdu_front.sv
// Front stages: products, exact sums and divider setup with multiply rounding.
// Depends on cmdu_pkg.
module cmdu_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  cmdu_pkg::req_t        req,
    output logic                  out_valid,
    output cmdu_pkg::div_t        out_data
);

    typedef struct packed
    {
        cmdu_pkg::cmd_t     cmd;
        logic signed [63:0] p_rr;
        logic signed [63:0] p_ii;
        logic signed [63:0] p_ri;
        logic signed [63:0] p_ir;
        logic [63:0]        sq_r;
        logic [63:0]        sq_i;
    } prod_t;

    typedef struct packed
    {
        cmdu_pkg::cmd_t cmd;
        logic           neg_re;
        logic           neg_im;
        logic [63:0]    mag_re;
        logic [63:0]    mag_im;
        logic [63:0]    den;
    } sum_t;

    logic  prod_valid_reg, sum_valid_reg, setup_valid_reg;
    prod_t prod_reg, prod_next;
    sum_t  sum_reg, sum_next;
    cmdu_pkg::div_t setup_reg, setup_next;

    logic signed [63:0] sq_r_s, sq_i_s;
    logic signed [64:0] s_re, s_im;
    logic [64:0] rnd_re, rnd_im;
    logic [32:0] sat_re, sat_im;
    logic [63+cmdu_pkg::INT_BITS:0] lim;

    always_comb
    begin
        sq_r_s         = req.b_re * req.b_re;
        sq_i_s         = req.b_im * req.b_im;
        prod_next.cmd  = req.cmd;
        prod_next.p_rr = req.a_re * req.b_re;
        prod_next.p_ii = req.a_im * req.b_im;
        prod_next.p_ri = req.a_re * req.b_im;
        prod_next.p_ir = req.a_im * req.b_re;
        prod_next.sq_r = sq_r_s;
        prod_next.sq_i = sq_i_s;
    end

    always_comb
    begin
        if (prod_reg.cmd == cmdu_pkg::CMD_MUL)
        begin
            s_re = {prod_reg.p_rr[63], prod_reg.p_rr} - {prod_reg.p_ii[63], prod_reg.p_ii};
            s_im = {prod_reg.p_ri[63], prod_reg.p_ri} + {prod_reg.p_ir[63], prod_reg.p_ir};
        end
        else
        begin
            s_re = {prod_reg.p_rr[63], prod_reg.p_rr} + {prod_reg.p_ii[63], prod_reg.p_ii};
            s_im = {prod_reg.p_ir[63], prod_reg.p_ir} - {prod_reg.p_ri[63], prod_reg.p_ri};
        end
        sum_next.cmd    = prod_reg.cmd;
        sum_next.neg_re = s_re[64];
        sum_next.neg_im = s_im[64];
        sum_next.mag_re = s_re[64] ? 64'(-s_re) : s_re[63:0];
        sum_next.mag_im = s_im[64] ? 64'(-s_im) : s_im[63:0];
        sum_next.den    = prod_reg.sq_r + prod_reg.sq_i;
    end

    always_comb
    begin
        rnd_re = ({1'b0, sum_reg.mag_re} + 65'(1 << (cmdu_pkg::FRAC_BITS - 1)))
                 >> cmdu_pkg::FRAC_BITS;
        rnd_im = ({1'b0, sum_reg.mag_im} + 65'(1 << (cmdu_pkg::FRAC_BITS - 1)))
                 >> cmdu_pkg::FRAC_BITS;
        sat_re = cmdu_pkg::sat32(sum_reg.neg_re, rnd_re[63:0]);
        sat_im = cmdu_pkg::sat32(sum_reg.neg_im, rnd_im[63:0]);
        lim    = {sum_reg.den, {cmdu_pkg::INT_BITS{1'b0}}};

        setup_next.cmd     = sum_reg.cmd;
        setup_next.dz      = (sum_reg.cmd == cmdu_pkg::CMD_DIV) && (sum_reg.den == 64'd0);
        setup_next.mul_re  = sat_re[31:0];
        setup_next.mul_im  = sat_im[31:0];
        setup_next.mul_ovf = sat_re[32] | sat_im[32];
        setup_next.den     = sum_reg.den;

        // quotient of 2^33 or more only means saturate
        setup_next.re.big = {{cmdu_pkg::INT_BITS{1'b0}}, sum_reg.mag_re} >= lim;
        setup_next.im.big = {{cmdu_pkg::INT_BITS{1'b0}}, sum_reg.mag_im} >= lim;
        setup_next.re.neg = sum_reg.neg_re;
        setup_next.im.neg = sum_reg.neg_im;
        setup_next.re.rem = sum_reg.mag_re >> cmdu_pkg::INT_BITS;
        setup_next.im.rem = sum_reg.mag_im >> cmdu_pkg::INT_BITS;
        setup_next.re.num = {sum_reg.mag_re[cmdu_pkg::INT_BITS-1:0],
                             {(cmdu_pkg::FRAC_BITS + 1){1'b0}}};
        setup_next.im.num = {sum_reg.mag_im[cmdu_pkg::INT_BITS-1:0],
                             {(cmdu_pkg::FRAC_BITS + 1){1'b0}}};
        setup_next.re.quo = '0;
        setup_next.im.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            sum_valid_reg   <= 1'b0;
            setup_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg  <= in_valid;
            sum_valid_reg   <= prod_valid_reg;
            setup_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        setup_reg <= setup_next;
    end

    assign out_valid = setup_valid_reg;
    assign out_data  = setup_reg;

endmodule

>>> hw/rtl/cmdu_div_stage.sv
// One restoring-division step for both lanes: one quotient bit each.
// Depends on cmdu_pkg.
module cmdu_div_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cmdu_pkg::div_t in_data,
    output logic           out_valid,
    output cmdu_pkg::div_t out_data
);

    logic           valid_reg;
    cmdu_pkg::div_t data_reg, data_next;
    logic [64:0]    trial_re, trial_im;
    logic           ge_re, ge_im;

    always_comb
    begin
        trial_re = {in_data.re.rem, in_data.re.num[cmdu_pkg::QBITS-1]};
        trial_im = {in_data.im.rem, in_data.im.num[cmdu_pkg::QBITS-1]};
        ge_re    = trial_re >= {1'b0, in_data.den};
        ge_im    = trial_im >= {1'b0, in_data.den};

        data_next        = in_data;
        data_next.re.rem = ge_re ? 64'(trial_re - {1'b0, in_data.den}) : trial_re[63:0];
        data_next.im.rem = ge_im ? 64'(trial_im - {1'b0, in_data.den}) : trial_im[63:0];
        data_next.re.num = in_data.re.num << 1;
        data_next.im.num = in_data.im.num << 1;
        data_next.re.quo = {in_data.re.quo[cmdu_pkg::QBITS-2:0], ge_re};
        data_next.im.quo = {in_data.im.quo[cmdu_pkg::QBITS-2:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/cmdu_back.sv
// Output stage: quotient rounding, saturation and result selection.
// Depends on cmdu_pkg.
module cmdu_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cmdu_pkg::div_t in_data,
    output logic           done,
    output cmdu_pkg::rsp_t rsp
);

    logic           done_reg;
    cmdu_pkg::rsp_t rsp_reg, rsp_next;
    logic [cmdu_pkg::QBITS:0] rq_re, rq_im;
    logic [63:0] mag_re, mag_im;
    logic [32:0] sat_re, sat_im;

    always_comb
    begin
        rq_re  = ({1'b0, in_data.re.quo} + 1'b1) >> 1;
        rq_im  = ({1'b0, in_data.im.quo} + 1'b1) >> 1;
        mag_re = in_data.re.big ? 64'h1_0000_0000 : 64'(rq_re);
        mag_im = in_data.im.big ? 64'h1_0000_0000 : 64'(rq_im);
        sat_re = cmdu_pkg::sat32(in_data.re.neg, mag_re);
        sat_im = cmdu_pkg::sat32(in_data.im.neg, mag_im);

        if (in_data.cmd == cmdu_pkg::CMD_MUL)
        begin
            rsp_next.res_re   = in_data.mul_re;
            rsp_next.res_im   = in_data.mul_im;
            rsp_next.overflow = in_data.mul_ovf;
            rsp_next.div_zero = 1'b0;
        end
        else if (in_data.dz)
        begin
            rsp_next.res_re   = '0;
            rsp_next.res_im   = '0;
            rsp_next.overflow = 1'b0;
            rsp_next.div_zero = 1'b1;
        end
        else
        begin
            rsp_next.res_re   = sat_re[31:0];
            rsp_next.res_im   = sat_im[31:0];
            rsp_next.overflow = sat_re[32] | sat_im[32];
            rsp_next.div_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> tb/sv/tb_complex_mul_div_unit_core.sv
// Testbench for complex_mul_div_unit_core: random and directed complex multiply/divide requests,
// each result checked against an in-bench fixed-point predictor. Depends on cmdu_pkg and the core.
module tb_complex_mul_div_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 37;
    localparam int STALL_LIMIT = 5000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmdu_pkg::req_t req;
    logic done;
    cmdu_pkg::rsp_t rsp;

    cmdu_pkg::req_t pending_reqs[$];
    cmdu_pkg::rsp_t expected_rsps[$];
    int   send_idle_pct;
    bit   hold_requests;
    int   errors;
    int   checked;
    int   quiet_cycles;
    int   n_mul;
    int   n_div;
    int   n_dz;
    int   n_ovf;

    complex_mul_div_unit_core uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sign-and-magnitude of an exact sum, which lies in (-2^63, 2^63]
    function automatic logic [63:0] magnitude(input logic [63:0] s, output logic neg);
        neg = s[63] && (s != 64'h8000_0000_0000_0000);
        magnitude = neg ? 64'd0 - s : s;
    endfunction

    function automatic logic [63:0] div_round(input logic [63:0] mag, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = mag / den;
        r = mag % den;
        if (q >= (64'd1 << (32 - cmdu_pkg::FRAC_BITS)))
            return 64'd1 << 32;
        for (int i = 0; i < cmdu_pkg::FRAC_BITS + 1; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    function automatic logic [32:0] clamp32(input logic neg, input logic [63:0] mag);
        if (!neg)
            return (mag > 64'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, mag[31:0]};
        if (mag > 64'h8000_0000)
            return {1'b1, 32'h8000_0000};
        mag = 64'd0 - mag;
        return {1'b0, mag[31:0]};
    endfunction

    function automatic cmdu_pkg::rsp_t complex_result(input cmdu_pkg::req_t r);
        cmdu_pkg::rsp_t o;
        logic [63:0] rr;
        logic [63:0] ii;
        logic [63:0] ri;
        logic [63:0] ir;
        logic [63:0] den;
        logic [63:0] m_re;
        logic [63:0] m_im;
        logic        n_re;
        logic        n_im;
        logic [32:0] s_re;
        logic [32:0] s_im;
        rr = 64'($signed(r.a_re) * $signed(r.b_re));
        ii = 64'($signed(r.a_im) * $signed(r.b_im));
        ri = 64'($signed(r.a_re) * $signed(r.b_im));
        ir = 64'($signed(r.a_im) * $signed(r.b_re));
        o = '0;
        if (r.cmd == cmdu_pkg::CMD_MUL)
        begin
            m_re = magnitude(rr - ii, n_re);
            m_im = magnitude(ri + ir, n_im);
            m_re = (m_re + (64'd1 << (cmdu_pkg::FRAC_BITS - 1))) >> cmdu_pkg::FRAC_BITS;
            m_im = (m_im + (64'd1 << (cmdu_pkg::FRAC_BITS - 1))) >> cmdu_pkg::FRAC_BITS;
        end
        else
        begin
            den = 64'($signed(r.b_re) * $signed(r.b_re))
                + 64'($signed(r.b_im) * $signed(r.b_im));
            if (den == 64'd0)
            begin
                o.div_zero = 1'b1;
                return o;
            end
            m_re = div_round(magnitude(rr + ii, n_re), den);
            m_im = div_round(magnitude(ir - ri, n_im), den);
        end
        s_re = clamp32(n_re, m_re);
        s_im = clamp32(n_im, m_im);
        o.res_re = s_re[31:0];
        o.res_im = s_im[31:0];
        o.overflow = s_re[32] | s_im[32];
        return o;
    endfunction

    function automatic logic [31:0] rand_part(input int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 'h60000)) - 'h30000);
            2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< 12;
        endcase
    endfunction

    task automatic queue_req(input cmdu_pkg::cmd_t c, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
        cmdu_pkg::req_t r;
        r.cmd = c;
        r.a_re = ar;
        r.a_im = ai;
        r.b_re = br;
        r.b_im = bi;
        pending_reqs.push_back(r);
    endtask

    task automatic drain_pipe();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    // driver: one request per accepted edge, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rsps.push_back(complex_result(req));
                if (req.cmd == cmdu_pkg::CMD_DIV) n_div++; else n_mul++;
            end
            if (start && busy)
            begin
                // hold the request until taken
            end
            else if (pending_reqs.size() != 0 && !hold_requests
                     && $urandom_range(0, 99) >= send_idle_pct)
            begin
                start <= 1'b1;
                req   <= pending_reqs.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result %p", $realtime, rsp);
                errors++;
            end
            else
            begin
                cmdu_pkg::rsp_t e;
                e = expected_rsps.pop_front();
                checked++;
                if (e.div_zero) n_dz++;
                if (e.overflow) n_ovf++;
                if (rsp.res_re !== e.res_re)
                    $display("%0t: res_re expected %h actual %h", $realtime, e.res_re, rsp.res_re);
                if (rsp.res_im !== e.res_im)
                    $display("%0t: res_im expected %h actual %h", $realtime, e.res_im, rsp.res_im);
                if (rsp.overflow !== e.overflow)
                    $display("%0t: overflow expected %b actual %b", $realtime, e.overflow,
                             rsp.overflow);
                if (rsp.div_zero !== e.div_zero)
                    $display("%0t: div_zero expected %b actual %b", $realtime, e.div_zero,
                             rsp.div_zero);
                if (rsp !== e)
                    errors++;
            end
        end
    end

    // watchdog: count cycles in which no request is accepted and no result arrives
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** complex_mul_div_unit_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int style;
        hold_requests = 1'b0;
        send_idle_pct = 23;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, both operations, zero divisor, saturation, halves
        queue_req(cmdu_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_req(cmdu_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_req(cmdu_pkg::CMD_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(cmdu_pkg::CMD_MUL, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);
        queue_req(cmdu_pkg::CMD_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);
        queue_req(cmdu_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0);
        queue_req(cmdu_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(cmdu_pkg::CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        queue_req(cmdu_pkg::CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_req(cmdu_pkg::CMD_DIV, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);
        queue_req(cmdu_pkg::CMD_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
        queue_req(cmdu_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
        queue_req(cmdu_pkg::CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
        queue_req(cmdu_pkg::CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_req(cmdu_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(cmdu_pkg::CMD_DIV, 32'h0000_0001, 32'h0, 32'h0003_0000, 32'h0);
        queue_req(cmdu_pkg::CMD_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0);
        queue_req(cmdu_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0002_0000, 32'h0);
        queue_req(cmdu_pkg::CMD_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_0001, 32'h8000_0000);
        queue_req(cmdu_pkg::CMD_MUL, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'hFF00_0000);
        queue_req(cmdu_pkg::CMD_MUL, 32'h0, 32'h0, 32'h0, 32'h0);

        // pause the sender, then resume it and wait until every queued request has its result back
        hold_requests = 1'b1;
        repeat (20) @(posedge clk);
        hold_requests = 1'b0;
        drain_pipe();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 80 : 0;
            for (int n = 0; n < 310; n++)
            begin
                style = $urandom_range(0, 3);
                if ($urandom_range(0, 15) == 0)
                    queue_req(cmdu_pkg::CMD_DIV, rand_part(style), rand_part(style),
                              32'h0, 32'h0);
                else
                    queue_req(cmdu_pkg::cmd_t'($urandom_range(0, 1)), rand_part(style),
                              rand_part($urandom_range(0, 3)), rand_part(style),
                              rand_part($urandom_range(0, 3)));
            end
            drain_pipe();
        end

        $display("Checked %0d results: %0d multiplies, %0d divides.", checked, n_mul, n_div);
        $display("Zero-divisor results %0d, saturated results %0d.", n_dz, n_ovf);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("** complex_mul_div_unit_core: PASSED **");
        else
            $display("** complex_mul_div_unit_core: FAILED **");
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cmdu_pkg.sv
hw/rtl/cmdu_front.sv
hw/rtl/cmdu_div_stage.sv
hw/rtl/cmdu_back.sv
hw/rtl/complex_mul_div_unit_core.sv
tb/sv/tb_complex_mul_div_unit_core.sv
